// ----- rtl/core/iptl_pkg.sv -----
// ----------------------------------------------------------------------------
// iptl_pkg
// Shared types and codes for the IPv4 trie country lookup block.
// ----------------------------------------------------------------------------
package iptl_pkg;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_BROKEN    = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int LAST_LEVEL  = 3;
  localparam logic [15:0] LEAF_MARK = 16'hFFFF;

  // one classified beat waiting for the back end
  typedef struct packed {
    logic        lookup;  // lookup, else trie write
    logic        wr_ok;   // write index lies inside the memory
    logic [15:0] index;
    logic [31:0] data;    // word to write, or address to look up
  } op_t;

  // queue state seen by the back end
  typedef struct packed {
    logic not_empty;
    op_t  head;
  } q_status_t;

endpackage

// ----- rtl/core/iptl_if.sv -----
// ----------------------------------------------------------------------------
// iptl channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface iptl_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] word_index;
  logic [31:0] word_value;
  logic [31:0] ip_address;

  modport source (output valid, command, word_index, word_value, ip_address, input ready);
  modport sink   (input valid, command, word_index, word_value, ip_address, output ready);
endinterface

interface iptl_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] code_first_char;
  logic [7:0] code_second_char;

  modport source (output valid, status, code_first_char, code_second_char, input ready);
  modport sink   (input valid, status, code_first_char, code_second_char, output ready);
endinterface

// ----- rtl/core/iptl_front.sv -----
// ----------------------------------------------------------------------------
// iptl_front
// Accepts request beats, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module iptl_front #(
  parameter int MEM_WORDS = 65536
) (
  iptl_in_if.sink      in_ch,
  input  logic         q_ready,
  output logic         q_push,
  output iptl_pkg::op_t q_entry
);
  import iptl_pkg::*;

  logic is_lookup;

  assign is_lookup   = (cmd_t'(in_ch.command) == CMD_LOOKUP);
  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid & q_ready;

  always_comb begin
    q_entry.lookup = is_lookup;
    // writes past the end of the memory are dropped
    q_entry.wr_ok  = (32'(in_ch.word_index) < 32'(MEM_WORDS));
    q_entry.index  = in_ch.word_index;
    q_entry.data   = is_lookup ? in_ch.ip_address : in_ch.word_value;
  end

endmodule

// ----- rtl/core/iptl_queue.sv -----
// ----------------------------------------------------------------------------
// iptl_queue
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
module iptl_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  iptl_pkg::op_t       push_entry,
  output logic                push_ready,
  input  logic                pop,
  output iptl_pkg::q_status_t q_status
);
  import iptl_pkg::*;

  op_t                 entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign do_push    = push & push_ready;
  assign do_pop     = pop & (count_r != '0);

  assign q_status.not_empty = (count_r != '0);
  assign q_status.head      = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/iptl_back.sv -----
// ----------------------------------------------------------------------------
// iptl_back
// Owns the trie memory, applies writes and walks the trie for lookups.
// ----------------------------------------------------------------------------
module iptl_back #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  iptl_pkg::q_status_t q_status,
  output logic                q_pop,
  iptl_out_if.source          out_ch
);
  import iptl_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0]   mem [MEM_WORDS];

  back_state_t   state_r, state_nxt;
  logic [1:0]    level_r;
  logic [23:0]   ip_r;
  logic [31:0]   rd_data_r;

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r;
  logic [7:0]    c1_r, c2_r;

  logic          leaf;
  logic [7:0]    next_octet;
  logic [30:0]   next_addr;
  logic          next_ok;
  logic          walk_done;
  logic          out_free;
  logic          start_lookup;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   wr_idx;
  logic          res_load;
  status_t       res_status;
  logic [7:0]    res_c1, res_c2;

  assign leaf     = (rd_data_r[31:16] == LEAF_MARK);
  assign out_free = !out_valid_r || out_ch.ready;
  assign wr_idx   = 32'(q_status.head.index);

  always_comb begin
    case (level_r)
      2'd0:    next_octet = ip_r[23:16];
      2'd1:    next_octet = ip_r[15:8];
      default: next_octet = ip_r[7:0];
    endcase
  end

  // word read at this level is a table pointer; form the next word address
  assign next_addr = {1'b0, rd_data_r[31:2]} + 31'(next_octet);
  assign next_ok   = (rd_data_r[1:0] == 2'b00) && (next_addr < 31'(MEM_WORDS))
                     && (level_r != 2'(LAST_LEVEL));
  assign walk_done = leaf || !next_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_status.not_empty && q_status.head.lookup) begin
          state_nxt = BK_WALK;
        end
      end
      BK_WALK: begin
        if (walk_done && out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop        = 1'b0;
    start_lookup = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = next_addr[AW-1:0];
    res_load     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        q_pop        = q_status.not_empty;
        start_lookup = q_status.not_empty && q_status.head.lookup;
        wr_en        = q_status.not_empty && !q_status.head.lookup && q_status.head.wr_ok;
        rd_en        = start_lookup;
        // root table sits at offset 0
        rd_addr      = AW'(q_status.head.data[31:24]);
      end
      BK_WALK: begin
        rd_en    = !walk_done;
        res_load = walk_done && out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_status = STATUS_BROKEN;
    res_c1     = '0;
    res_c2     = '0;
    if (leaf) begin
      if (rd_data_r[15:0] == 16'h0000) begin
        res_status = STATUS_NOT_FOUND;
      end else begin
        res_status = STATUS_FOUND;
        res_c1     = rd_data_r[15:8];
        res_c2     = rd_data_r[7:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_lookup) begin
      level_r <= 2'd0;
      ip_r    <= q_status.head.data[23:0];
    end else if (rd_en) begin
      level_r <= level_r + 2'd1;
    end
    if (res_load) begin
      status_r <= res_status;
      c1_r     <= res_c1;
      c2_r     <= res_c2;
    end
  end

  // trie memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx[AW-1:0]] <= q_status.head.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.code_first_char  = c1_r;
  assign out_ch.code_second_char = c2_r;

  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (state_r == BK_WALK) && out_free)
    else $error("result loaded outside a walk or over a pending result");

  a_no_read_past_last_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) && rd_en |-> (level_r != 2'(LAST_LEVEL)))
    else $error("trie read issued beyond the last level");

  a_walk_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) && rd_en |-> (next_addr < 31'(MEM_WORDS)))
    else $error("trie read address past the memory");

  a_pop_only_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_status.not_empty && (state_r == BK_IDLE))
    else $error("queue popped while empty or busy");

  a_walk_starts_at_root: assert property (@(posedge clk) disable iff (!rst_n)
    start_lookup |=> (state_r == BK_WALK) && (level_r == 2'd0))
    else $error("lookup did not start at the root level");

endmodule

// ----- rtl/core/ipv4_trie_country_lookup.sv -----
// ----------------------------------------------------------------------------
// ipv4_trie_country_lookup
// Stride-8 four-level trie lookup of IPv4 addresses to country codes.
// ----------------------------------------------------------------------------
// Request beats either write one 32-bit trie word or look up an address; only
// lookups return a result beat. The front end takes a beat whenever the
// four-entry queue has room, so it keeps accepting while a result waits at the
// output register. The back end owns the trie memory, with one write and one
// read port, and takes one queued item at a time: a write is applied as it is
// popped; a lookup issues the root read as it is popped and then reads one trie
// level at a time, as every level needs the previous level's word on the read port.
// A lookup whose result cannot be handed over stays in its last level until the
// output register frees up. Trie words are undefined until written.
module ipv4_trie_country_lookup #(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  iptl_in_if.sink     in_ch,
  iptl_out_if.source  out_ch
);
  import iptl_pkg::*;

  logic      q_push;
  logic      q_ready;
  logic      q_pop;
  op_t       q_entry;
  q_status_t q_status;

  iptl_front #(
    .MEM_WORDS (MEM_WORDS)
  ) u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  iptl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .q_status   (q_status)
  );

  iptl_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule
